// ===== sv/bhte_pkg.sv =====
package bhte_pkg;

    localparam int NUM_BINS_DEF      = 1024;
    localparam int SLOTS_PER_BIN_DEF = 4;

    localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
    localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
    localparam logic [63:0] FM_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FM_C2 = 64'hc4ceb9fe1a85ec53;

    localparam logic [2:0] FUNC_QUERY  = 3'd0;
    localparam logic [2:0] FUNC_DELETE = 3'd1;
    localparam logic [2:0] FUNC_UPSERT = 3'd2;
    localparam logic [2:0] FUNC_INSERT = 3'd3;
    localparam logic [2:0] FUNC_UPDATE = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MISS    = 3'd1;
    localparam logic [2:0] ST_EXISTS  = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BADKEY  = 3'd4;

    // multiplier step codes
    typedef enum logic [2:0] {
        MOP_K1,
        MOP_K2,
        MOP_A1,
        MOP_A2,
        MOP_B1,
        MOP_B2
    } mop_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_MULW,
        S_FIN,
        S_RD,
        S_SCAN,
        S_DONE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul_go;
        mop_t mop;
        logic fin;
        logic rd_go;
        logic scan;
        logic decide;
        logic clr;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic scan_last;
        logic clr_last;
        logic zero_key;
    } sts_t;

endpackage

// ===== sv/bhte_mul.sv =====
module bhte_mul
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] p
);

    // 64x64 low product from three 32x32 partials, one per cycle
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] opa, opb;
    logic [63:0] part;

    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                opa = a[31:0];
                opb = b[31:0];
            end
            2'd1:
            begin
                opa = a[63:32];
                opb = b[31:0];
            end
            2'd2:
            begin
                opa = a[31:0];
                opb = b[63:32];
            end
            default:
            begin
                opa = a[31:0];
                opb = b[31:0];
            end
        endcase
        part = opa * opb;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (go)
        begin
            busy_next = 1'b1;
            step_next = 2'd0;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                2'd0:    acc_next = acc_reg + part;
                default: acc_next = acc_reg + {part[31:0], 32'd0};
            endcase
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd2)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign done = busy_reg && (step_reg == 2'd2);
    assign p    = acc_next;

endmodule

// ===== sv/bhte_ctrl.sv =====
module bhte_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  bhte_pkg::sts_t  sts,
    output bhte_pkg::cmd_t  cmd,
    output logic            busy
);

    bhte_pkg::state_t state_reg, state_next;
    bhte_pkg::mop_t   mop_reg, mop_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bhte_pkg::S_CLEAR;
            mop_reg   <= bhte_pkg::MOP_K1;
        end
        else
        begin
            state_reg <= state_next;
            mop_reg   <= mop_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mop_next   = mop_reg;
        cmd        = '0;
        cmd.mop    = mop_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        busy       = 1'b1;
        case (state_reg)
            bhte_pkg::S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                    state_next = bhte_pkg::S_IDLE;
            end
            bhte_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    mop_next   = bhte_pkg::MOP_K1;
                    state_next = bhte_pkg::S_MUL;
                end
            end
            bhte_pkg::S_MUL:
            begin
                if (sts.zero_key)
                    state_next = bhte_pkg::S_DONE;
                else
                begin
                    cmd.mul_go = 1'b1;
                    state_next = bhte_pkg::S_MULW;
                end
            end
            bhte_pkg::S_MULW:
            begin
                if (sts.mul_done)
                begin
                    case (mop_reg)
                        bhte_pkg::MOP_K1: begin mop_next = bhte_pkg::MOP_K2;
                            state_next = bhte_pkg::S_MUL; end
                        bhte_pkg::MOP_K2: begin mop_next = bhte_pkg::MOP_A1;
                            state_next = bhte_pkg::S_MUL; end
                        bhte_pkg::MOP_A1: begin mop_next = bhte_pkg::MOP_A2;
                            state_next = bhte_pkg::S_MUL; end
                        bhte_pkg::MOP_A2: begin mop_next = bhte_pkg::MOP_B1;
                            state_next = bhte_pkg::S_MUL; end
                        bhte_pkg::MOP_B1: begin mop_next = bhte_pkg::MOP_B2;
                            state_next = bhte_pkg::S_MUL; end
                        default: state_next = bhte_pkg::S_FIN;
                    endcase
                end
            end
            bhte_pkg::S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = bhte_pkg::S_RD;
            end
            bhte_pkg::S_RD:
            begin
                cmd.rd_go  = 1'b1;
                state_next = bhte_pkg::S_SCAN;
            end
            bhte_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                    state_next = bhte_pkg::S_DONE;
            end
            bhte_pkg::S_DONE:
            begin
                cmd.decide = 1'b1;
                state_next = bhte_pkg::S_OUT;
            end
            bhte_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = bhte_pkg::S_IDLE;
            end
            default: state_next = bhte_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== sv/bhte_dp.sv =====
module bhte_dp
#(
    parameter int NUM_BINS      = bhte_pkg::NUM_BINS_DEF,
    parameter int SLOTS_PER_BIN = bhte_pkg::SLOTS_PER_BIN_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  bhte_pkg::cmd_t  cmd,
    output bhte_pkg::sts_t  sts,
    input  logic [31:0]     seed,
    input  logic [2:0]      func,
    input  logic [63:0]     key,
    input  logic [63:0]     value,
    output logic [2:0]      status,
    output logic            found,
    output logic [63:0]     value_out,
    output logic [12:0]     entry_total
);

    localparam int BIN_W   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int SLOT_W  = (SLOTS_PER_BIN > 1) ? $clog2(SLOTS_PER_BIN) : 1;
    localparam int DEPTH   = NUM_BINS * SLOTS_PER_BIN;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SCNT_W  = $clog2(SLOTS_PER_BIN + 1);
    localparam logic [63:0] BIN_MASK = 64'(NUM_BINS - 1);

    logic [63:0] key_mem [DEPTH];
    logic [63:0] val_mem [DEPTH];

    logic [2:0]  func_reg;
    logic [63:0] key_reg, val_reg;
    logic [63:0] a_reg, b_reg, k_reg;
    logic [BIN_W-1:0] bin_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [SCNT_W-1:0] rd_reg;
    logic [SCNT_W-1:0] sc_reg;
    logic        rdv_reg;
    logic [63:0] rkey_reg, rval_reg;
    logic        hit_reg, emp_reg;
    logic [SLOT_W-1:0] hs_reg, es_reg;
    logic [63:0] hval_reg;
    logic [12:0] cnt_reg;
    logic [2:0]  status_reg, status_next;
    logic        found_reg, found_next;
    logic [63:0] vout_reg, vout_next;

    logic [63:0] ma, mb, mp;
    logic        mdone;
    logic [63:0] kr, a1, b1, h_a, h_b;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [SLOT_W-1:0] sidx;
    logic        wk_en, wv_en;
    logic [63:0] wk_data;
    logic        hit, is_del, is_wr;

    function automatic logic [63:0] rotl31(input logic [63:0] x);
        return {x[32:0], x[63:33]};
    endfunction

    bhte_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.mul_go),
        .a     (ma),
        .b     (mb),
        .done  (mdone),
        .p     (mp)
    );

    always_comb
    begin
        kr = rotl31(k_reg);
        a1 = {32'd0, seed} ^ mp ^ 64'd8;
        b1 = {32'd0, seed} ^ 64'd8;
        case (cmd.mop)
            bhte_pkg::MOP_K1:
            begin
                ma = key_reg;
                mb = bhte_pkg::MM_C1;
            end
            bhte_pkg::MOP_K2:
            begin
                ma = kr;
                mb = bhte_pkg::MM_C2;
            end
            bhte_pkg::MOP_A1:
            begin
                ma = a_reg ^ (a_reg >> 33);
                mb = bhte_pkg::FM_C1;
            end
            bhte_pkg::MOP_A2:
            begin
                ma = a_reg ^ (a_reg >> 33);
                mb = bhte_pkg::FM_C2;
            end
            bhte_pkg::MOP_B1:
            begin
                ma = b_reg ^ (b_reg >> 33);
                mb = bhte_pkg::FM_C1;
            end
            default:
            begin
                ma = b_reg ^ (b_reg >> 33);
                mb = bhte_pkg::FM_C2;
            end
        endcase
        h_a = a_reg ^ (a_reg >> 33);
        h_b = b_reg ^ (b_reg >> 33);
    end

    assign sts.mul_done  = mdone;
    assign sts.zero_key  = (key_reg == 64'd0);
    assign sts.scan_last = rdv_reg && (sc_reg == SCNT_W'(SLOTS_PER_BIN - 1));
    assign sts.clr_last  = (clr_reg == ADDR_W'(DEPTH - 1));

    // hash state
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            key_reg  <= key;
            val_reg  <= value;
        end
        if (mdone)
        begin
            case (cmd.mop)
                bhte_pkg::MOP_K1: k_reg <= mp;
                bhte_pkg::MOP_K2:
                begin
                    k_reg <= mp;
                    a_reg <= a1 + b1;
                    b_reg <= b1 + (a1 + b1);
                end
                bhte_pkg::MOP_A1, bhte_pkg::MOP_A2: a_reg <= mp;
                default: b_reg <= mp;
            endcase
        end
        if (cmd.fin)
            bin_reg <= BIN_W'((h_a + h_b + h_b) & BIN_MASK);
    end

    // bin scan: one slot read per cycle
    assign rd_addr = ADDR_W'(bin_reg * SLOTS_PER_BIN) + ADDR_W'(rd_reg);
    assign sidx    = SLOT_W'(sc_reg);

    always_ff @(posedge clk)
    begin
        rkey_reg <= key_mem[rd_addr];
        rval_reg <= val_mem[rd_addr];
        if (wk_en)
            key_mem[wr_addr] <= wk_data;
        if (wv_en)
            val_mem[wr_addr] <= val_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            rd_reg  <= '0;
            sc_reg  <= '0;
            rdv_reg <= 1'b0;
            hit_reg <= 1'b0;
            emp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.clr)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.rd_go)
            begin
                rd_reg  <= SCNT_W'(1);
                sc_reg  <= '0;
                rdv_reg <= 1'b1;
                hit_reg <= 1'b0;
                emp_reg <= 1'b0;
            end
            else if (cmd.scan && rdv_reg)
            begin
                rd_reg <= rd_reg + 1'b1;
                sc_reg <= sc_reg + 1'b1;
                if (rkey_reg == key_reg && !hit_reg)
                    hit_reg <= 1'b1;
                if (rkey_reg == 64'd0 && !emp_reg)
                    emp_reg <= 1'b1;
                if (sts.scan_last)
                    rdv_reg <= 1'b0;
            end
            else if (cmd.load)
            begin
                rd_reg  <= '0;
                hit_reg <= 1'b0;
                emp_reg <= 1'b0;
            end
            if (cmd.decide && !sts.zero_key)
            begin
                if (is_del)
                    cnt_reg <= cnt_reg - 13'd1;
                else if (is_wr && wk_en)
                    cnt_reg <= cnt_reg + 13'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan && rdv_reg)
        begin
            if (rkey_reg == key_reg && !hit_reg)
            begin
                hs_reg   <= sidx;
                hval_reg <= rval_reg;
            end
            if (rkey_reg == 64'd0 && !emp_reg)
                es_reg <= sidx;
        end
    end

    // decision and store update
    assign hit = hit_reg;
    always_comb
    begin
        is_del  = 1'b0;
        is_wr   = 1'b0;
        wk_en   = 1'b0;
        wv_en   = 1'b0;
        wk_data = key_reg;
        wr_addr = ADDR_W'(bin_reg * SLOTS_PER_BIN) + ADDR_W'(es_reg);
        if (cmd.clr)
        begin
            wk_en   = 1'b1;
            wk_data = '0;
            wr_addr = clr_reg;
        end
        else if (cmd.decide && !sts.zero_key)
        begin
            case (func_reg)
                bhte_pkg::FUNC_DELETE:
                begin
                    if (hit)
                    begin
                        is_del  = 1'b1;
                        wk_en   = 1'b1;
                        wk_data = '0;
                        wr_addr = ADDR_W'(bin_reg * SLOTS_PER_BIN) + ADDR_W'(hs_reg);
                    end
                end
                bhte_pkg::FUNC_UPSERT, bhte_pkg::FUNC_INSERT, bhte_pkg::FUNC_UPDATE:
                begin
                    is_wr = 1'b1;
                    if (hit)
                    begin
                        wr_addr = ADDR_W'(bin_reg * SLOTS_PER_BIN) + ADDR_W'(hs_reg);
                        wv_en   = (func_reg != bhte_pkg::FUNC_INSERT);
                    end
                    else if (func_reg != bhte_pkg::FUNC_UPDATE && emp_reg)
                    begin
                        wk_en = 1'b1;
                        wv_en = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        found_next  = 1'b0;
        vout_next   = '0;
        status_next = bhte_pkg::ST_OK;
        if (sts.zero_key)
            status_next = bhte_pkg::ST_BADKEY;
        else
        begin
            found_next = hit;
            case (func_reg)
                bhte_pkg::FUNC_DELETE:
                begin
                    if (!hit)
                        status_next = bhte_pkg::ST_MISS;
                end
                bhte_pkg::FUNC_UPSERT:
                begin
                    if (!hit && !emp_reg)
                        status_next = bhte_pkg::ST_FULL;
                end
                bhte_pkg::FUNC_INSERT:
                begin
                    if (hit)
                        status_next = bhte_pkg::ST_EXISTS;
                    else if (!emp_reg)
                        status_next = bhte_pkg::ST_FULL;
                end
                bhte_pkg::FUNC_UPDATE:
                begin
                    if (!hit)
                        status_next = bhte_pkg::ST_MISS;
                end
                default:
                begin
                    if (hit)
                        vout_next = hval_reg;
                    else
                        status_next = bhte_pkg::ST_MISS;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            found_reg  <= found_next;
            vout_reg   <= vout_next;
            status_reg <= status_next;
        end
    end

    assign status      = status_reg;
    assign found       = found_reg;
    assign value_out   = vout_reg;
    assign entry_total = cnt_reg;

endmodule

// ===== sv/bucketed_hash_table_engine.sv =====
// channel   direction  handshake      payload
// in        input      valid/stall    func, key, value
// out       output     valid/stall    status, found, value_out, entry_total
// cfg       input      valid/ready    hash seed
// an item runs six 64-bit multiplies, each a start and three 32x32 partial
// steps on one shared multiplier, then one key/value memory read per slot of
// the bin, and then waits for its result to be taken
// a zero key skips hashing and scan and goes straight to its result
// after reset the key memory is cleared, one entry a cycle, all
// NUM_BINS*SLOTS_PER_BIN entries, before the first item is taken
// one item in flight; in_stall stays high until its result is transferred
module bucketed_hash_table_engine
#(
    parameter int NUM_BINS      = bhte_pkg::NUM_BINS_DEF,
    parameter int SLOTS_PER_BIN = bhte_pkg::SLOTS_PER_BIN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [63:0] key,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        found,
    output logic [63:0] value_out,
    output logic [12:0] entry_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] hash_seed
);

    bhte_pkg::cmd_t cmd;
    bhte_pkg::sts_t sts;
    logic           busy;
    logic [31:0]    seed_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (cfg_valid && cfg_ready)
            seed_reg <= hash_seed;
    end

    bhte_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    bhte_dp #(.NUM_BINS(NUM_BINS), .SLOTS_PER_BIN(SLOTS_PER_BIN)) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .seed        (seed_reg),
        .func        (func),
        .key         (key),
        .value       (value),
        .status      (status),
        .found       (found),
        .value_out   (value_out),
        .entry_total (entry_total)
    );

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(value_out))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !in_stall && !out_valid)
        else $error("idle state inconsistent");

endmodule
